// ===== hdl/tsws_pkg.sv =====
`timescale 1ns / 1ps
package tsws_pkg;
  localparam int TASK_SLOTS = 16;
  localparam int SEMAPHORES = 4;
  localparam int COUNT_BITS = 16;
  localparam int TID_W = $clog2(TASK_SLOTS);
  localparam int CNT_W = $clog2(TASK_SLOTS + 1);
  localparam int SEM_W = 2;
  localparam int SEMQ_DEPTH = SEMAPHORES * TASK_SLOTS;
  localparam int SEMQ_AW = $clog2(SEMQ_DEPTH);
  localparam int SIDX_W = (SEMAPHORES > 1) ? $clog2(SEMAPHORES) : 1;

  typedef enum logic [2:0] {
    ACT_CREATE = 3'd0,
    ACT_IDLE   = 3'd1,
    ACT_YIELD  = 3'd2,
    ACT_DELAY  = 3'd3,
    ACT_INIT   = 3'd4,
    ACT_WAIT   = 3'd5,
    ACT_POST   = 3'd6,
    ACT_EXIT   = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    STS_OK   = 2'd0,
    STS_FULL = 2'd1,
    STS_NORUN = 2'd2,
    STS_SAT  = 2'd3
  } status_t;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_CMD   = 8'b00000010,
    S_SRD   = 8'b00000100,
    S_SCHK  = 8'b00001000,
    S_DISP  = 8'b00010000,
    S_DRD   = 8'b00100000,
    S_PRD   = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_t;
endpackage

// ===== hdl/task_scheduler_with_semaphores.sv =====
`timescale 1ns / 1ps
// Round-robin task scheduler with counting semaphores.
// Input channel: in_valid/in_stall with in_action, in_tick_count, in_sem_index,
// in_sem_start. Result channel: out_valid/out_stall with one item per command:
// out_status, out_task_id, out_dispatched, out_unblocked, out_gave_up,
// out_woken, out_count_after.
// Commands run one at a time. Create, yield, delay, exit, init, wait and a
// post without waiters go from the command state to the output state; a post
// that releases a waiter passes a queue-read state between them. An idle pass
// walks the sleep list one entry at a time (delay memory read, then write
// back), then checks for a task to dispatch, with one more state when a task
// is dispatched.
// A new item is accepted once the core is idle and the output register is
// empty, so a new item is taken only after the last result has been taken. The
// output register holds while out_stall is high and the input stalls meanwhile.
// Reset (rst_n low, synchronous) empties all queues, marks all slots unused,
// zeroes the semaphores and leaves no task running. No clearing pass.
module task_scheduler_with_semaphores
  import tsws_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            in_action,
  input  logic [31:0]           in_tick_count,
  input  logic [1:0]            in_sem_index,
  input  logic [15:0]           in_sem_start,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_status,
  output logic [3:0]            out_task_id,
  output logic                  out_dispatched,
  output logic                  out_unblocked,
  output logic                  out_gave_up,
  output logic [4:0]            out_woken,
  output logic [15:0]           out_count_after
);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  state_t state_r, state_nxt;
  action_t act_r;
  logic [31:0] ticks_r;
  logic [1:0] sidx_r;
  logic [15:0] start_r;

  logic [CNT_W-1:0] created_r;
  logic [TID_W-1:0] rq_head_r, rq_tail_r;
  logic [CNT_W-1:0] rq_cnt_r;
  logic [CNT_W-1:0] sleep_len_r;
  logic [CNT_W-1:0] si_r, sk_r;
  logic [COUNT_BITS-1:0] sem_cnt_r [SEMAPHORES];
  logic [TID_W-1:0] sq_head_r [SEMAPHORES];
  logic [TID_W-1:0] sq_tail_r [SEMAPHORES];
  logic [CNT_W-1:0] sq_cnt_r [SEMAPHORES];
  logic run_valid_r;
  logic [TID_W-1:0] running_r;
  logic [TID_W-1:0] cur_id_r;

  logic [1:0] o_status_r;
  logic [3:0] o_tid_r;
  logic o_disp_r, o_unbl_r, o_gave_r;
  logic [4:0] o_woken_r;
  logic [15:0] o_cnt_r;
  logic out_valid_r;

  // memories
  logic dl_we;
  logic [TID_W-1:0] dl_waddr, dl_raddr;
  logic [31:0] dl_wdata, dl_rdata;
  logic so_we;
  logic [TID_W-1:0] so_waddr, so_raddr;
  logic [TID_W-1:0] so_wdata, so_rdata;
  logic rq_we;
  logic [TID_W-1:0] rq_waddr, rq_raddr;
  logic [TID_W-1:0] rq_wdata, rq_rdata;
  logic sq_we;
  logic [SEMQ_AW-1:0] sq_waddr, sq_raddr;
  logic [TID_W-1:0] sq_wdata, sq_rdata;

  tsws_ram #(.WIDTH(32), .DEPTH(TASK_SLOTS)) u_delay (
    .clk(clk), .we(dl_we), .waddr(dl_waddr), .wdata(dl_wdata),
    .raddr(dl_raddr), .rdata(dl_rdata));
  tsws_ram #(.WIDTH(TID_W), .DEPTH(TASK_SLOTS)) u_sleep (
    .clk(clk), .we(so_we), .waddr(so_waddr), .wdata(so_wdata),
    .raddr(so_raddr), .rdata(so_rdata));
  tsws_ram #(.WIDTH(TID_W), .DEPTH(TASK_SLOTS)) u_ready (
    .clk(clk), .we(rq_we), .waddr(rq_waddr), .wdata(rq_wdata),
    .raddr(rq_raddr), .rdata(rq_rdata));
  tsws_ram #(.WIDTH(TID_W), .DEPTH(SEMQ_DEPTH)) u_semq (
    .clk(clk), .we(sq_we), .waddr(sq_waddr), .wdata(sq_wdata),
    .raddr(sq_raddr), .rdata(sq_rdata));

  logic in_take, out_take;
  logic sem_ok;
  logic [SIDX_W-1:0] sidx;
  logic [31:0] dec;

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;
  assign in_stall = (state_r != S_IDLE) || out_valid_r;
  assign sidx     = sidx_r[SIDX_W-1:0];
  assign sem_ok   = ({30'd0, sidx_r} < SEMAPHORES);
  assign dec      = dl_rdata - 32'd1;

  always_comb begin
    dl_we = 1'b0; dl_waddr = running_r; dl_wdata = ticks_r; dl_raddr = so_rdata;
    so_we = 1'b0; so_waddr = sleep_len_r[TID_W-1:0]; so_wdata = running_r;
    so_raddr = si_r[TID_W-1:0];
    rq_we = 1'b0; rq_waddr = rq_tail_r; rq_wdata = running_r; rq_raddr = rq_head_r;
    sq_we = 1'b0;
    sq_waddr = {sidx_r, sq_tail_r[sidx]};
    sq_wdata = running_r;
    sq_raddr = {sidx_r, sq_head_r[sidx]};
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_take) state_nxt = S_CMD;
      S_CMD: begin
        unique case (act_r)
          ACT_CREATE: begin
            rq_wdata = created_r[TID_W-1:0];
            rq_we = (created_r < CNT_W'(TASK_SLOTS)) && (rq_cnt_r < CNT_W'(TASK_SLOTS));
            state_nxt = S_OUT;
          end
          ACT_IDLE: state_nxt = (sleep_len_r != '0) ? S_SRD : S_DISP;
          ACT_YIELD, ACT_DELAY, ACT_EXIT: begin
            if (run_valid_r) begin
              if (act_r == ACT_DELAY && ticks_r != '0) begin
                dl_we = 1'b1;
                so_we = (sleep_len_r < CNT_W'(TASK_SLOTS));
              end else if (act_r != ACT_EXIT) begin
                rq_we = (rq_cnt_r < CNT_W'(TASK_SLOTS));
              end
            end
            state_nxt = S_OUT;
          end
          ACT_WAIT: begin
            sq_we = sem_ok && run_valid_r && (sem_cnt_r[sidx] == '0) &&
                    (sq_cnt_r[sidx] < CNT_W'(TASK_SLOTS));
            state_nxt = S_OUT;
          end
          ACT_POST: begin
            state_nxt = (sem_ok && sq_cnt_r[sidx] != '0) ? S_PRD : S_OUT;
          end
          default: state_nxt = S_OUT;
        endcase
      end
      S_SRD: state_nxt = S_SCHK;
      S_SCHK: begin
        dl_we = 1'b1; dl_waddr = cur_id_r; dl_wdata = dec;
        if (dec == '0) begin
          rq_we = (rq_cnt_r < CNT_W'(TASK_SLOTS));
          rq_wdata = cur_id_r;
        end else begin
          so_we = 1'b1; so_waddr = sk_r[TID_W-1:0]; so_wdata = cur_id_r;
        end
        so_raddr = si_r[TID_W-1:0];
        state_nxt = (si_r < sleep_len_r) ? S_SRD : S_DISP;
      end
      S_DISP: state_nxt = (!run_valid_r && rq_cnt_r != '0) ? S_DRD : S_OUT;
      S_DRD: state_nxt = S_OUT;
      S_PRD: begin
        rq_we = (rq_cnt_r < CNT_W'(TASK_SLOTS));
        rq_wdata = sq_rdata;
        state_nxt = S_OUT;
      end
      S_OUT: if (!out_valid_r || out_take) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      created_r <= '0;
      rq_head_r <= '0; rq_tail_r <= '0; rq_cnt_r <= '0;
      sleep_len_r <= '0;
      run_valid_r <= 1'b0;
      running_r <= '0;
      out_valid_r <= 1'b0;
      for (int s = 0; s < SEMAPHORES; s++) begin
        sem_cnt_r[s] <= '0;
        sq_head_r[s] <= '0; sq_tail_r[s] <= '0; sq_cnt_r[s] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (out_take) out_valid_r <= 1'b0;
      else if (state_r == S_OUT) out_valid_r <= 1'b1;
      if (rq_we) begin
        rq_tail_r <= rq_tail_r + 1'b1;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_take) begin
            act_r <= action_t'(in_action);
            ticks_r <= in_tick_count;
            sidx_r <= in_sem_index;
            start_r <= in_sem_start;
            o_status_r <= STS_OK; o_tid_r <= '0; o_disp_r <= 1'b0;
            o_unbl_r <= 1'b0; o_gave_r <= 1'b0; o_woken_r <= '0; o_cnt_r <= '0;
            si_r <= '0; sk_r <= '0;
          end
        end
        S_CMD: begin
          unique case (act_r)
            ACT_CREATE: begin
              if (created_r >= CNT_W'(TASK_SLOTS)) begin
                o_status_r <= STS_FULL;
              end else begin
                o_tid_r <= 4'(created_r);
                created_r <= created_r + 1'b1;
                if (rq_cnt_r < CNT_W'(TASK_SLOTS)) rq_cnt_r <= rq_cnt_r + 1'b1;
              end
            end
            ACT_YIELD, ACT_DELAY, ACT_EXIT: begin
              if (!run_valid_r) begin
                o_status_r <= STS_NORUN;
              end else begin
                o_tid_r <= 4'(running_r);
                o_gave_r <= 1'b1;
                run_valid_r <= 1'b0;
                if (act_r == ACT_DELAY && ticks_r != '0) begin
                  if (sleep_len_r < CNT_W'(TASK_SLOTS)) sleep_len_r <= sleep_len_r + 1'b1;
                end else if (act_r != ACT_EXIT) begin
                  if (rq_cnt_r < CNT_W'(TASK_SLOTS)) rq_cnt_r <= rq_cnt_r + 1'b1;
                end
              end
            end
            ACT_INIT: begin
              if (sem_ok) begin
                if ({16'd0, start_r} > {{(32 - COUNT_BITS){1'b0}}, CMAX}) begin
                  sem_cnt_r[sidx] <= CMAX;
                  o_cnt_r <= 16'(CMAX);
                  o_status_r <= STS_SAT;
                end else begin
                  sem_cnt_r[sidx] <= COUNT_BITS'(start_r);
                  o_cnt_r <= start_r;
                end
                sq_head_r[sidx] <= '0; sq_tail_r[sidx] <= '0; sq_cnt_r[sidx] <= '0;
              end
            end
            ACT_WAIT: begin
              if (sem_ok) begin
                if (!run_valid_r) begin
                  o_status_r <= STS_NORUN;
                  o_cnt_r <= 16'(sem_cnt_r[sidx]);
                end else if (sem_cnt_r[sidx] != '0) begin
                  sem_cnt_r[sidx] <= sem_cnt_r[sidx] - 1'b1;
                  o_cnt_r <= 16'(sem_cnt_r[sidx] - 1'b1);
                end else begin
                  o_cnt_r <= 16'(sem_cnt_r[sidx]);
                  o_tid_r <= 4'(running_r);
                  o_gave_r <= 1'b1;
                  run_valid_r <= 1'b0;
                  if (sq_cnt_r[sidx] < CNT_W'(TASK_SLOTS)) begin
                    sq_tail_r[sidx] <= sq_tail_r[sidx] + 1'b1;
                    sq_cnt_r[sidx] <= sq_cnt_r[sidx] + 1'b1;
                  end
                end
              end
            end
            ACT_POST: begin
              if (sem_ok) begin
                if (sq_cnt_r[sidx] != '0) begin
                  o_cnt_r <= 16'(sem_cnt_r[sidx]);
                  sq_head_r[sidx] <= sq_head_r[sidx] + 1'b1;
                  sq_cnt_r[sidx] <= sq_cnt_r[sidx] - 1'b1;
                end else if (sem_cnt_r[sidx] == CMAX) begin
                  o_cnt_r <= 16'(sem_cnt_r[sidx]);
                  o_status_r <= STS_SAT;
                end else begin
                  sem_cnt_r[sidx] <= sem_cnt_r[sidx] + 1'b1;
                  o_cnt_r <= 16'(sem_cnt_r[sidx] + 1'b1);
                end
              end
            end
            default: ;
          endcase
        end
        S_SRD: begin
          si_r <= si_r + 1'b1;
          cur_id_r <= so_rdata;
        end
        S_SCHK: begin
          if (dec == '0) begin
            if (rq_cnt_r < CNT_W'(TASK_SLOTS)) rq_cnt_r <= rq_cnt_r + 1'b1;
            if (o_woken_r != 5'd31) o_woken_r <= o_woken_r + 1'b1;
          end else begin
            sk_r <= sk_r + 1'b1;
          end
          if (!(si_r < sleep_len_r)) begin
            sleep_len_r <= (dec == '0) ? sk_r : sk_r + 1'b1;
          end
        end
        S_DISP: begin
          if (run_valid_r) o_tid_r <= 4'(running_r);
        end
        S_DRD: begin
          running_r <= rq_rdata;
          run_valid_r <= 1'b1;
          rq_head_r <= rq_head_r + 1'b1;
          rq_cnt_r <= rq_cnt_r - 1'b1;
          o_tid_r <= 4'(rq_rdata);
          o_disp_r <= 1'b1;
        end
        S_PRD: begin
          o_tid_r <= 4'(sq_rdata);
          o_unbl_r <= 1'b1;
          if (rq_cnt_r < CNT_W'(TASK_SLOTS)) rq_cnt_r <= rq_cnt_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = o_status_r;
  assign out_task_id     = o_tid_r;
  assign out_dispatched  = o_disp_r;
  assign out_unblocked   = o_unbl_r;
  assign out_gave_up     = o_gave_r;
  assign out_woken       = o_woken_r;
  assign out_count_after = o_cnt_r;
endmodule

// ===== hdl/tsws_ram.sv =====
`timescale 1ns / 1ps
module tsws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== verif/task_scheduler_with_semaphores_tb.sv =====
`timescale 1ns / 1ps
module task_scheduler_with_semaphores_tb;
  import tsws_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  task_id;
    logic        dispatched;
    logic        unblocked;
    logic        gave_up;
    logic [4:0]  woken;
    logic [15:0] count_after;
  } sched_result_t;

  localparam logic [2:0] TS_READY = 3'd1;
  localparam logic [2:0] TS_RUNNING = 3'd2;
  localparam logic [2:0] TS_SLEEPING = 3'd3;
  localparam logic [2:0] TS_BLOCKED = 3'd4;
  localparam logic [2:0] TS_EXITED = 3'd5;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  class sched_scoreboard;
    logic [2:0]  slot_state [TASK_SLOTS];
    logic [31:0] slot_delay [TASK_SLOTS];
    int          created;
    int          ready_list [$];
    int          sleepers [$];
    logic [15:0] sem_count [SEMAPHORES];
    int          sem_waiters [SEMAPHORES][$];
    bit          have_running;
    int          running_id;
    sched_result_t pending [$];
    int          mismatches;

    function new();
      for (int i = 0; i < TASK_SLOTS; i++) begin
        slot_state[i] = 0;
        slot_delay[i] = 0;
      end
      for (int s = 0; s < SEMAPHORES; s++) begin
        sem_count[s] = 0;
        sem_waiters[s].delete();
      end
      created = 0;
      have_running = 0;
      running_id = 0;
      mismatches = 0;
    endfunction

    function void note_command(action_t act, logic [31:0] ticks, logic [1:0] sidx,
                               logic [15:0] start);
      sched_result_t r;
      int still [$];
      int id;
      r = '0;
      case (act)
        ACT_CREATE: begin
          if (created >= TASK_SLOTS) r.status = STS_FULL;
          else begin
            r.task_id = 4'(created);
            slot_state[created] = TS_READY;
            slot_delay[created] = 0;
            if (ready_list.size() < TASK_SLOTS) ready_list.push_back(created);
            created++;
          end
        end
        ACT_IDLE: begin
          foreach (sleepers[i]) begin
            id = sleepers[i];
            slot_delay[id] = slot_delay[id] - 1;
            if (slot_delay[id] == 0) begin
              slot_state[id] = TS_READY;
              if (ready_list.size() < TASK_SLOTS) ready_list.push_back(id);
              if (r.woken < 31) r.woken++;
            end else still.push_back(id);
          end
          sleepers = still;
          if (have_running) r.task_id = 4'(running_id);
          else if (ready_list.size() > 0) begin
            running_id = ready_list.pop_front();
            have_running = 1;
            slot_state[running_id] = TS_RUNNING;
            r.task_id = 4'(running_id);
            r.dispatched = 1;
          end
        end
        ACT_YIELD, ACT_DELAY, ACT_EXIT: begin
          if (!have_running) r.status = STS_NORUN;
          else begin
            r.task_id = 4'(running_id);
            r.gave_up = 1;
            have_running = 0;
            if (act == ACT_EXIT) slot_state[running_id] = TS_EXITED;
            else if (act == ACT_DELAY && ticks != 0) begin
              slot_delay[running_id] = ticks;
              slot_state[running_id] = TS_SLEEPING;
              if (sleepers.size() < TASK_SLOTS) sleepers.push_back(running_id);
            end else begin
              slot_state[running_id] = TS_READY;
              if (ready_list.size() < TASK_SLOTS) ready_list.push_back(running_id);
            end
          end
        end
        default: begin
          if (sidx < SEMAPHORES) begin
            if (act == ACT_INIT) begin
              sem_count[sidx] = start;
              sem_waiters[sidx].delete();
            end else if (act == ACT_WAIT) begin
              if (!have_running) r.status = STS_NORUN;
              else if (sem_count[sidx] > 0) sem_count[sidx]--;
              else begin
                r.task_id = 4'(running_id);
                r.gave_up = 1;
                have_running = 0;
                slot_state[running_id] = TS_BLOCKED;
                if (sem_waiters[sidx].size() < TASK_SLOTS)
                  sem_waiters[sidx].push_back(running_id);
              end
            end else begin
              if (sem_waiters[sidx].size() > 0) begin
                id = sem_waiters[sidx].pop_front();
                r.task_id = 4'(id);
                slot_state[id] = TS_READY;
                if (ready_list.size() < TASK_SLOTS) ready_list.push_back(id);
                r.unblocked = 1;
              end else if (sem_count[sidx] == COUNT_MAX) r.status = STS_SAT;
              else sem_count[sidx]++;
            end
            r.count_after = sem_count[sidx];
          end
        end
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(sched_result_t got);
      sched_result_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", exp, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [2:0] in_action = '0;
  logic [31:0] in_tick_count = '0;
  logic [1:0] in_sem_index = '0;
  logic [15:0] in_sem_start = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [1:0] out_status;
  logic [3:0] out_task_id;
  logic out_dispatched, out_unblocked, out_gave_up;
  logic [4:0] out_woken;
  logic [15:0] out_count_after;

  int send_idle_pct = 0;
  int stall_pct = 0;
  bit long_hold = 0;
  bit hold_active = 0;
  sched_scoreboard board;

  always #5 clk = ~clk;

  task_scheduler_with_semaphores i_dut (.*);

  initial begin
    wait (long_hold);
    @(posedge clk);
    hold_active <= 1;
    repeat (300) @(posedge clk);
    hold_active <= 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        board.check_result({out_status, out_task_id, out_dispatched, out_unblocked,
                            out_gave_up, out_woken, out_count_after});
      if (hold_active) out_stall <= 1;
      else out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_command(action_t act, logic [31:0] ticks, logic [1:0] sidx,
                              logic [15:0] start);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_action <= act;
    in_tick_count <= ticks;
    in_sem_index <= sidx;
    in_sem_start <= start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_command(act, ticks, sidx, start);
  endtask

  task automatic send_random();
    int pick;
    logic [31:0] ticks;
    pick = $urandom_range(99);
    ticks = ($urandom_range(9) == 0) ? $urandom : $urandom_range(4);
    if ($urandom_range(19) == 0) ticks = 32'hFFFF_FFFF;
    if (pick < 8) send_command(ACT_CREATE, $urandom, 2'($urandom), 16'($urandom));
    else if (pick < 40) send_command(ACT_IDLE, $urandom, 2'($urandom), 16'($urandom));
    else if (pick < 50) send_command(ACT_YIELD, $urandom, 2'($urandom), 16'($urandom));
    else if (pick < 62) send_command(ACT_DELAY, ticks, 2'($urandom), 16'($urandom));
    else if (pick < 67)
      send_command(ACT_INIT, $urandom, 2'($urandom),
                   16'(($urandom_range(3) == 0) ? $urandom : $urandom_range(2)));
    else if (pick < 82) send_command(ACT_WAIT, $urandom, 2'($urandom), 16'($urandom));
    else if (pick < 97) send_command(ACT_POST, $urandom, 2'($urandom), 16'($urandom));
    else send_command(ACT_EXIT, $urandom, 2'($urandom), 16'($urandom));
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 0;
    while (board.pending.size() > 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (60) @(posedge clk);
  endtask

  initial begin
    board = new();
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_command(ACT_YIELD, 0, 0, 0);
    send_command(ACT_DELAY, 5, 0, 0);
    send_command(ACT_EXIT, 0, 0, 0);
    send_command(ACT_WAIT, 0, 1, 0);
    send_command(ACT_IDLE, 0, 0, 0);
    send_command(ACT_POST, 0, 3, 0);
    send_command(ACT_INIT, 0, 2, 16'hFFFF);
    send_command(ACT_POST, 0, 2, 0);
    send_command(ACT_INIT, 0, 1, 0);
    for (int i = 0; i < 3; i++) send_command(ACT_CREATE, 0, 0, 0);
    send_command(ACT_IDLE, 0, 0, 0);
    send_command(ACT_IDLE, 0, 0, 0);
    send_command(ACT_DELAY, 0, 0, 0);
    send_command(ACT_IDLE, 0, 0, 0);
    send_command(ACT_WAIT, 0, 1, 0);
    send_command(ACT_IDLE, 0, 0, 0);
    send_command(ACT_DELAY, 32'hFFFF_FFFF, 0, 0);
    send_command(ACT_IDLE, 0, 0, 0);
    send_command(ACT_POST, 0, 1, 0);
    send_command(ACT_INIT, 0, 1, 16'h5A5A);
    send_command(ACT_EXIT, 0, 0, 0);
    send_command(ACT_IDLE, 0, 0, 0);
    send_command(ACT_WAIT, 0, 3, 0);
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 45; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 45; end
        3: begin send_idle_pct = 32; stall_pct = 32; end
        default: begin send_idle_pct = 0; stall_pct = 0; end
      endcase
      if (ph == 4) long_hold = 1;
      for (int n = 0; n < 185; n++) send_random();
    end
    drain();
    if (board.mismatches == 0 && board.pending.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end
endmodule

// ===== files.f =====
hdl/tsws_pkg.sv
hdl/tsws_ram.sv
hdl/task_scheduler_with_semaphores.sv
verif/task_scheduler_with_semaphores_tb.sv
